FILE: rtl/core/nearest_point_search_3d_macros.svh
// Assertion macros for the nearest point search block.
// Used by the datapath; no other dependencies.
`ifndef NEAREST_POINT_SEARCH_3D_MACROS_SVH
`define NEAREST_POINT_SEARCH_3D_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define NPS3D_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition in the next cycle follows from a trigger.
`define NPS3D_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    `NPS3D_ASSERT(label, clk, rst_n, (trig) |=> (cons), msg)

`endif

FILE: rtl/core/nps3d_pkg.sv
// Shared types and constants for the nearest point search block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nps3d_pkg;

    localparam int IDX_OUT_W  = 10;
    localparam int DIST_OUT_W = 36;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic take;      // input beat accepted this cycle
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_idle; // no read issued and no point in flight
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/core/nps3d_if.sv
// Valid/ready channel interfaces for the item and result streams.
// Depends on nps3d_pkg for the result field widths.
`timescale 1ns / 1ps
`default_nettype none

interface nps3d_in_if #(
    parameter int COORD_BITS = 16
);
    import nps3d_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;

    modport source (output valid, output op, output pos_x, output pos_y, output pos_z,
                    input ready);
    modport sink   (input valid, input op, input pos_x, input pos_y, input pos_z,
                    output ready);
endinterface

interface nps3d_out_if;
    import nps3d_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [IDX_OUT_W-1:0]  nearest_index;
    logic                  found;
    logic                  table_full;
    logic [DIST_OUT_W-1:0] best_distance_sq;

    modport source (output valid, output nearest_index, output found, output table_full,
                    output best_distance_sq, input ready);
    modport sink   (input valid, input nearest_index, input found, input table_full,
                    input best_distance_sq, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nps3d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nps3d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/nps3d_ctrl.sv
// Sequencing state machine: input handshake, scan wait, result hand-off.
// Depends on nps3d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nps3d_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_ready,
    input  wire nps3d_pkg::t_stat i_stat,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output nps3d_pkg::t_cmd      o_cmd
);
    import nps3d_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.take     = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // wait for the last point to clear the compare stage
                if (i_stat.scan_idle) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // load once the output slot is free or draining now
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/nps3d_dp.sv
// Datapath: point table, point count, distance pipeline, best tracker, output register.
// Depends on nps3d_pkg, nps3d_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_point_search_3d_macros.svh"

module nps3d_dp #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire nps3d_pkg::t_cmd                    i_cmd,
    input  wire logic                               i_op,
    input  wire logic [COORD_BITS-1:0]              i_pos_x,
    input  wire logic [COORD_BITS-1:0]              i_pos_y,
    input  wire logic [COORD_BITS-1:0]              i_pos_z,
    output nps3d_pkg::t_stat                        o_stat,
    output logic [nps3d_pkg::IDX_OUT_W-1:0]         o_nearest_index,
    output logic                                    o_found,
    output logic                                    o_table_full,
    output logic [nps3d_pkg::DIST_OUT_W-1:0]        o_best_distance_sq
);
    import nps3d_pkg::*;

    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int C   = COORD_BITS;
    localparam int DW  = 2 * C + 2;  // holds 3 * 2^(2C) with headroom
    localparam int RW  = 3 * C;
    localparam int IXW = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
    localparam int DXW = (DW > DIST_OUT_W) ? DW : DIST_OUT_W;

    // control state
    logic [CW-1:0] r_count;
    logic          r_issue;
    logic          r_v1, r_v2, r_v3, r_v4;

    // payload
    logic [IW-1:0]   r_rd_addr;
    logic [C-1:0]    r_qx, r_qy, r_qz;
    logic [IW-1:0]   r_idx1, r_idx2, r_idx3, r_idx4;
    logic [C:0]      r_ax, r_ay, r_az;
    logic [DW-1:0]   r_sqx, r_sqy, r_sqz;
    logic [DW-1:0]   r_sum;
    logic [IW-1:0]   r_best_idx;
    logic [DW-1:0]   r_best_d;
    logic            r_found;
    logic            r_full;

    logic            is_add;
    logic            is_full;
    logic            wr_en;
    logic            last_issue;
    logic [RW-1:0]   rd_data;
    logic [C-1:0]    px, py, pz;
    logic signed [C:0] dx, dy, dz;
    logic [IXW-1:0]  idx_ext;
    logic [DXW-1:0]  dist_ext;

    assign is_add     = (i_op == OP_ADD);
    assign is_full    = (r_count == CW'(MAX_POINTS));
    assign wr_en      = i_cmd.take && is_add && !is_full;
    assign last_issue = ((CW'(r_rd_addr) + CW'(1)) == r_count);

    nps3d_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (IW'(r_count)),
        .i_wdata ({i_pos_x, i_pos_y, i_pos_z}),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    assign {px, py, pz} = rd_data;

    // signed differences, one bit wider than a coordinate
    assign dx = $signed({r_qx[C-1], r_qx}) - $signed({px[C-1], px});
    assign dy = $signed({r_qy[C-1], r_qy}) - $signed({py[C-1], py});
    assign dz = $signed({r_qz[C-1], r_qz}) - $signed({pz[C-1], pz});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.take) begin
                r_issue <= !is_add && (r_count != '0);
            end else if (r_issue && last_issue) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // read address and query latch
        if (i_cmd.take) begin
            r_rd_addr <= '0;
            r_qx      <= i_pos_x;
            r_qy      <= i_pos_y;
            r_qz      <= i_pos_z;
        end else if (r_issue) begin
            r_rd_addr <= r_rd_addr + IW'(1);
        end

        // distance pipeline: magnitude, square, sum
        r_idx1 <= r_rd_addr;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_idx4 <= r_idx3;
        r_ax   <= dx[C] ? (~dx + 1'b1) : dx;
        r_ay   <= dy[C] ? (~dy + 1'b1) : dy;
        r_az   <= dz[C] ? (~dz + 1'b1) : dz;
        r_sqx  <= DW'(r_ax) * DW'(r_ax);
        r_sqy  <= DW'(r_ay) * DW'(r_ay);
        r_sqz  <= DW'(r_az) * DW'(r_az);
        r_sum  <= r_sqx + r_sqy + r_sqz;

        // result tracker; only a strictly smaller distance replaces the best
        if (i_cmd.take) begin
            if (is_add) begin
                r_found    <= 1'b0;
                r_best_d   <= '0;
                r_full     <= is_full;
                r_best_idx <= is_full ? '0 : IW'(r_count);
            end else begin
                r_found    <= (r_count != '0);
                r_best_d   <= '1;
                r_full     <= 1'b0;
                r_best_idx <= '0;
            end
        end else if (r_v4 && (r_sum < r_best_d)) begin
            r_best_d   <= r_sum;
            r_best_idx <= r_idx4;
        end

        if (i_cmd.out_load) begin
            o_nearest_index    <= idx_ext[IDX_OUT_W-1:0];
            o_found            <= r_found;
            o_table_full       <= r_full;
            o_best_distance_sq <= r_found ? dist_ext[DIST_OUT_W-1:0] : '0;
        end
    end

    assign idx_ext  = IXW'(r_best_idx);
    assign dist_ext = DXW'(r_best_d);

    assign o_stat.scan_idle = !(r_issue || r_v1 || r_v2 || r_v3 || r_v4);

    `NPS3D_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_POINTS), "point count past capacity")
    `NPS3D_ASSERT(a_read_in_range, i_clk, i_rst_n, r_issue |-> (CW'(r_rd_addr) < r_count), "read beyond stored points")
    `NPS3D_ASSERT_NEXT(a_pipe_empty_on_take, i_clk, i_rst_n, i_cmd.take, !r_v1 && !r_v4, "stale point in pipeline")
    `NPS3D_ASSERT(a_compare_only_on_query, i_clk, i_rst_n, r_v4 |-> r_found, "compare outside a query")

endmodule

`default_nettype wire

FILE: rtl/core/nearest_point_search_3d.sv
// Nearest point search: add beats append a point; query beats scan every stored point
// for the nearest one. The table RAM read port scans one point per cycle, and a new
// beat is accepted only once the previous result is in the output register.
// An empty-table query skips the scan, as an add does. Reset (sync, active low) empties
// the table and clears all handshakes; the table RAM itself is never cleared.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_search_3d #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    nps3d_in_if.sink     i_in,
    nps3d_out_if.source  o_out
);
    import nps3d_pkg::*;

    // Command and status between sequencer and datapath.
    t_cmd  cmd;
    t_stat stat;

    // Sequencer: accepts one beat at a time in idle, waits for the scan to drain,
    // then hands the result to the output register as soon as its slot frees.
    // A new beat is taken while a finished result still waits downstream.
    nps3d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // Datapath: appends points on add beats; on query beats streams every stored
    // point through difference, square and sum stages into the best tracker.
    nps3d_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_op               (i_in.op),
        .i_pos_x            (i_in.pos_x),
        .i_pos_y            (i_in.pos_y),
        .i_pos_z            (i_in.pos_z),
        .o_stat             (stat),
        .o_nearest_index    (o_out.nearest_index),
        .o_found            (o_out.found),
        .o_table_full       (o_out.table_full),
        .o_best_distance_sq (o_out.best_distance_sq)
    );

endmodule

`default_nettype wire
